FILE: src/qpse_pkg.sv
// shared types, constants and table function for the quadrature pot sensor emulator
package qpse_pkg;

   localparam int POT_COUNT_DEFAULT       = 7;
   localparam int PHASE_BITS_DEFAULT      = 16;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   localparam logic [11:0] MIDSCALE      = 12'd2048;
   localparam logic [11:0] READING_MAX   = 12'd4095;
   localparam logic [10:0] AMP_RESET     = 11'd2000;
   localparam logic [11:0] BATT_RESET    = 12'd1461;
   localparam logic [15:0] SLIDER0_RESET = 16'd22938;
   localparam logic [15:0] SLIDER1_RESET = 16'd32768;

   // sine table entries are Q15, full scale 32768 needs 16 bits
   localparam int SINE_W = 16;

   localparam longint Q30_ONE = 64'sd1073741824;

   typedef enum logic [0:0] {
      CSR_AMPLITUDE = 1'b0,
      CSR_BATTERY   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_MID  = 2'd0,
      KIND_BATT = 2'd1,
      KIND_POT  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0]  channel;
      logic [15:0] slider;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] reading;
      logic        above_mid;
   } rsp_payload_type;

   // odd degree-9 polynomial in q30, rounded to q15 and clamped
   function automatic logic [SINE_W-1:0] sine_entry(input int idx, input int bits);
      longint t;
      longint t2;
      longint acc;
      longint r;
      t   = longint'(idx) * (Q30_ONE >>> bits);
      t2  = (t * t) / Q30_ONE;
      acc = 64'sd172272;
      acc = -64'sd5026990 + (acc * t2) / Q30_ONE;
      acc = 64'sd85569306 + (acc * t2) / Q30_ONE;
      acc = -64'sd693598656 + (acc * t2) / Q30_ONE;
      acc = 64'sd1686629713 + (acc * t2) / Q30_ONE;
      r   = (acc * t) / Q30_ONE;
      if (r < 0) r = 0;
      r = (r + 64'sd16384) >>> 15;
      if (r > 64'sd32768) r = 64'sd32768;
      return SINE_W'(r);
   endfunction

endpackage

FILE: src/qpse_ram.sv
// generic single-write, single-read ram with registered read data
module qpse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/qpse_sine_rom.sv
// quarter-wave sine rom, contents folded from the package function, registered read
module qpse_sine_rom #(
   parameter int TABLE_BITS = qpse_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          re,
   input  logic [TABLE_BITS:0]           addr,
   output logic [qpse_pkg::SINE_W-1:0]   data
);

   localparam int DEPTH = (1 << TABLE_BITS) + 1;

   logic [qpse_pkg::SINE_W-1:0] rom_table [DEPTH];
   logic [qpse_pkg::SINE_W-1:0] data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      assign rom_table[i] = qpse_pkg::sine_entry(i, TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (re) begin
         data_ff <= rom_table[addr];
      end
   end

   assign data = data_ff;

endmodule

FILE: src/quadrature_pot_sensor_emulator_core.sv
// top level of the quadrature pot sensor emulator: decode, pot state update, sine lookup, scaling
//
//   port group  direction  word / fields              handshake
//   req_        in         channel[7:0], slider[15:0]  req_valid / req_ready
//   rsp_        out        reading[11:0], above_mid    rsp_valid / rsp_ready
//   csr_        in         index[0], wdata[11:0]       csr_we, no wait
//
// one word per cycle sustained, unless rsp_ready holds off a full output register
// stage 1 reads pot state from ram, stage 2 reads the sine rom, stage 3 scales into the
// output register; a write-back forwarding register covers the same pot on adjacent words
// all stages advance together when the output register is empty or being taken
// synchronous reset clears valid bits; untouched pots read their reset slider and zero phase
module quadrature_pot_sensor_emulator_core #(
   parameter int POT_COUNT       = qpse_pkg::POT_COUNT_DEFAULT,
   parameter int PHASE_BITS      = qpse_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = qpse_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  qpse_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output qpse_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_we,
   input  qpse_pkg::csr_index_type   csr_index,
   input  logic [11:0]               csr_wdata
);

   localparam int KW       = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;
   localparam int EW       = 16 + PHASE_BITS;
   localparam int IB       = SINE_TABLE_BITS + 2;
   localparam int SW       = PHASE_BITS + 18;
   localparam int UP       = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
   localparam int DN       = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
   localparam int CHAN_END = 2 + 2 * POT_COUNT;
   localparam logic [SINE_TABLE_BITS:0] QUARTER = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);
   localparam logic signed [28:0] MID_Q15 = 29'sd67108864;

   // configuration
   logic [10:0] amp_ff;
   logic [11:0] batt_ff;

   // pipeline control
   logic adv;
   logic accept;

   // decode of the incoming word
   logic [7:0]        ch;
   logic [7:0]        ch_m2;
   logic              in_is_pot;
   qpse_pkg::kind_type in_kind;
   logic [KW-1:0]     in_k;

   // stage 1
   logic              s1_valid_ff, s1_valid_in;
   qpse_pkg::kind_type s1_kind_ff;
   logic [KW-1:0]     s1_k_ff;
   logic              s1_y_ff;
   logic [15:0]       s1_slider_ff;

   // stage 2
   logic              s2_valid_ff, s2_valid_in;
   qpse_pkg::kind_type s2_kind_ff;
   logic              s2_neg_ff;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   qpse_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // pot state valid bits and forwarding
   logic [POT_COUNT-1:0] pot_valid_ff, pot_valid_in;
   logic                 fwd_valid_ff;
   logic [KW-1:0]        fwd_addr_ff;
   logic [EW-1:0]        fwd_data_ff;

   // ram and rom
   logic                       ram_we;
   logic [EW-1:0]              ram_wdata;
   logic [EW-1:0]              ram_rdata;
   logic [SINE_TABLE_BITS:0]   rom_addr;
   logic [qpse_pkg::SINE_W-1:0] rom_data;

   // stage 1 datapath
   logic [EW-1:0]           cur_entry;
   logic [15:0]             cur_last;
   logic [PHASE_BITS-1:0]   cur_phase;
   logic signed [16:0]      ds;
   logic signed [17:0]      dgain;
   logic signed [SW-1:0]    d_ext;
   logic signed [SW-1:0]    step_wide;
   logic [PHASE_BITS-1:0]   new_phase;
   logic [PHASE_BITS-1:0]   use_phase;
   logic [PHASE_BITS+IB-1:0] phase_pad;
   logic [IB-1:0]           idx;
   logic [1:0]              quad;
   logic [SINE_TABLE_BITS-1:0] frac;

   // output datapath
   logic [26:0]         mag;
   logic signed [28:0]  sum;
   logic [13:0]         scaled;
   logic [11:0]         pot_reading;
   logic [11:0]         sel_reading;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // decode
   always_comb begin
      ch        = req_data.channel;
      ch_m2     = ch - 8'd2;
      in_is_pot = (ch >= 8'd2) && (ch < 8'(CHAN_END));
      in_k      = ch_m2[KW:1];
      if (ch == 8'd1) begin
         in_kind = qpse_pkg::KIND_BATT;
      end else if (in_is_pot) begin
         in_kind = qpse_pkg::KIND_POT;
      end else begin
         in_kind = qpse_pkg::KIND_MID;
      end
   end

   qpse_ram #(
      .WIDTH (EW),
      .DEPTH (POT_COUNT)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_k_ff),
      .wdata (ram_wdata),
      .re    (accept && in_is_pot),
      .raddr (in_k),
      .rdata (ram_rdata)
   );

   // stage 1: pick current state, update phase, form table address
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_k_ff)) begin
         cur_entry = fwd_data_ff;
      end else if (!pot_valid_ff[s1_k_ff]) begin
         // never written: reset slider by pot, zero phase
         if (s1_k_ff == KW'(0)) begin
            cur_entry = {qpse_pkg::SLIDER0_RESET, {PHASE_BITS{1'b0}}};
         end else if (s1_k_ff == KW'(1)) begin
            cur_entry = {qpse_pkg::SLIDER1_RESET, {PHASE_BITS{1'b0}}};
         end else begin
            cur_entry = '0;
         end
      end else begin
         cur_entry = ram_rdata;
      end
      cur_last  = cur_entry[EW-1:PHASE_BITS];
      cur_phase = cur_entry[PHASE_BITS-1:0];

      ds = $signed({1'b0, s1_slider_ff}) - $signed({1'b0, cur_last});
      if (s1_k_ff == KW'(0)) begin
         dgain = {ds, 1'b0};
      end else if (s1_k_ff == KW'(1)) begin
         dgain = {ds[16], ds};
      end else begin
         dgain = -$signed({ds[16], ds});
      end
      d_ext     = {{(SW-18){dgain[17]}}, dgain};
      step_wide = (d_ext <<< UP) >>> DN;
      new_phase = cur_phase + step_wide[PHASE_BITS-1:0];
      use_phase = s1_y_ff ? cur_phase : new_phase;

      phase_pad = {use_phase, {IB{1'b0}}};
      idx       = phase_pad[PHASE_BITS +: IB];
      // cosine is sine a quarter turn ahead
      quad      = idx[IB-1:IB-2] + {1'b0, !s1_y_ff};
      frac      = idx[SINE_TABLE_BITS-1:0];
      rom_addr  = quad[0] ? (QUARTER - {1'b0, frac}) : {1'b0, frac};

      ram_we    = adv && s1_valid_ff && (s1_kind_ff == qpse_pkg::KIND_POT) && !s1_y_ff;
      ram_wdata = {s1_slider_ff, new_phase};

      pot_valid_in = pot_valid_ff;
      if (ram_we) begin
         pot_valid_in[s1_k_ff] = 1'b1;
      end
   end

   qpse_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock (clock),
      .re    (adv && s1_valid_ff),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   // output stage: scale, offset and clamp
   always_comb begin
      mag = 27'(rom_data) * 27'(amp_ff);
      if (s2_neg_ff) begin
         sum = MID_Q15 - $signed({2'b00, mag});
      end else begin
         sum = MID_Q15 + $signed({2'b00, mag});
      end
      if (sum < 0) begin
         scaled = '0;
      end else begin
         scaled = sum[28:15];
      end
      pot_reading = (scaled > 14'(qpse_pkg::READING_MAX)) ? qpse_pkg::READING_MAX
                                                          : scaled[11:0];
      case (s2_kind_ff)
         qpse_pkg::KIND_BATT: sel_reading = batt_ff;
         qpse_pkg::KIND_POT:  sel_reading = pot_reading;
         default:             sel_reading = qpse_pkg::MIDSCALE;
      endcase
      rsp_data_in.reading   = sel_reading;
      rsp_data_in.above_mid = sel_reading > qpse_pkg::MIDSCALE;

      s1_valid_in  = adv ? accept : s1_valid_ff;
      s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = adv ? s2_valid_ff : rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff       <= qpse_pkg::AMP_RESET;
         batt_ff      <= qpse_pkg::BATT_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pot_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               qpse_pkg::CSR_AMPLITUDE: amp_ff  <= csr_wdata[10:0];
               qpse_pkg::CSR_BATTERY:   batt_ff <= csr_wdata;
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pot_valid_ff <= pot_valid_in;
         if (adv) begin
            fwd_valid_ff <= ram_we;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= in_kind;
         s1_k_ff      <= in_k;
         s1_y_ff      <= ch_m2[0];
         s1_slider_ff <= req_data.slider;
      end
      if (adv) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_neg_ff   <= quad[1];
         fwd_addr_ff <= s1_k_ff;
         fwd_data_ff <= ram_wdata;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // forwarded entry must also be marked written
   a_fwd_marked: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> pot_valid_ff[fwd_addr_ff])
      else $error("forwarded pot entry not marked valid");

   // pot words carry an in-range pot number
   a_pot_range: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_kind_ff == qpse_pkg::KIND_POT)) |-> (s1_k_ff < KW'(POT_COUNT)))
      else $error("pot index out of range in stage 1");

   // a stalled pipeline holds its stage 1 word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && s1_valid_ff) |=> (s1_valid_ff && $stable(s1_k_ff) && $stable(s1_slider_ff)))
      else $error("stage 1 word changed during stall");

   // no ram write-back while stalled
   a_no_write_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |-> !ram_we)
      else $error("state ram written during stall");

   // reset leaves every pot unwritten
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (pot_valid_ff == '0) && !fwd_valid_ff)
      else $error("pot valid bits not cleared by reset");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the quadrature pot sensor emulator core
module tb_top;

   localparam int POTS          = qpse_pkg::POT_COUNT_DEFAULT;
   localparam int QUARTER_STEPS = 1 << qpse_pkg::SINE_TABLE_BITS_DEFAULT;
   localparam longint ONE_Q30   = 64'sd1073741824;
   localparam longint MID_Q15   = 64'sd67108864;

   localparam logic [7:0] CH_MID       = 8'd0;
   localparam logic [7:0] CH_BATT      = 8'd1;
   localparam logic [7:0] CH_POT_FIRST = 8'd2;
   localparam logic [7:0] CH_POT_LAST  = 8'(2 * POTS + 1);
   localparam logic [7:0] CH_FAR       = 8'd255;

   localparam int ITEMS_PER_PHASE = 250;
   localparam int DIRECTED_ROWS   = 25;

   typedef struct packed {
      logic [7:0]  channel;
      logic [15:0] slider;
      logic        known;
      logic [11:0] reading;
      logic        above_mid;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   qpse_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   qpse_pkg::rsp_payload_type rsp_data;
   logic                      csr_we = 1'b0;
   qpse_pkg::csr_index_type   csr_index = qpse_pkg::CSR_AMPLITUDE;
   logic [11:0]               csr_wdata = '0;

   // predictor state
   int                        sine_quarter [0:QUARTER_STEPS];
   logic [10:0]               amp_reg;
   logic [11:0]               batt_reg;
   logic [15:0]               pot_slider [POTS];
   logic [15:0]               pot_angle [POTS];
   qpse_pkg::rsp_payload_type predicted_readings [$];

   int              fail_count = 0;
   int              rsp_stall = 0;
   bit              quiet = 1'b0;

   stim_row_type stim_table [DIRECTED_ROWS] = '{
      '{CH_MID,        16'h0000, 1'b1, 12'd2048, 1'b0},
      '{CH_BATT,       16'hFFFF, 1'b1, 12'd1461, 1'b0},
      '{8'd3,          16'h0000, 1'b1, 12'd2048, 1'b0},
      '{8'd2,          16'd22938, 1'b1, 12'd4048, 1'b1},
      '{8'd4,          16'd32768, 1'b1, 12'd4048, 1'b1},
      '{8'd5,          16'd1234, 1'b1, 12'd2048, 1'b0},
      '{CH_POT_LAST,   16'h0000, 1'b1, 12'd2048, 1'b0},
      '{8'd14,         16'h0000, 1'b1, 12'd4048, 1'b1},
      '{8'd16,         16'hFFFF, 1'b1, 12'd2048, 1'b0},
      '{CH_FAR,        16'hAAAA, 1'b1, 12'd2048, 1'b0},
      '{8'd128,        16'h5555, 1'b1, 12'd2048, 1'b0},
      '{8'd2,          16'h0000, 1'b0, 12'd0, 1'b0},
      '{8'd3,          16'hFFFF, 1'b0, 12'd0, 1'b0},
      '{8'd2,          16'hFFFF, 1'b0, 12'd0, 1'b0},
      '{8'd3,          16'h0000, 1'b0, 12'd0, 1'b0},
      '{8'd4,          16'h0000, 1'b0, 12'd0, 1'b0},
      '{8'd5,          16'h0000, 1'b0, 12'd0, 1'b0},
      '{8'd4,          16'hFFFF, 1'b0, 12'd0, 1'b0},
      '{8'd6,          16'h4000, 1'b0, 12'd0, 1'b0},
      '{8'd7,          16'h0000, 1'b0, 12'd0, 1'b0},
      '{8'd6,          16'h0000, 1'b0, 12'd0, 1'b0},
      '{8'd8,          16'h8000, 1'b0, 12'd0, 1'b0},
      '{8'd10,         16'h4000, 1'b0, 12'd0, 1'b0},
      '{8'd12,         16'hC000, 1'b0, 12'd0, 1'b0},
      '{8'd13,         16'h0000, 1'b0, 12'd0, 1'b0}
   };

   quadrature_pot_sensor_emulator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // quarter-wave sine in q15 from an odd polynomial evaluated in q30
   function automatic void fill_sine_quarter();
      longint t;
      longint t2;
      longint acc;
      longint r;
      for (int i = 0; i <= QUARTER_STEPS; i++) begin
         t   = longint'(i) * (ONE_Q30 / QUARTER_STEPS);
         t2  = (t * t) / ONE_Q30;
         acc = 64'sd172272;
         acc = -64'sd5026990 + (acc * t2) / ONE_Q30;
         acc = 64'sd85569306 + (acc * t2) / ONE_Q30;
         acc = -64'sd693598656 + (acc * t2) / ONE_Q30;
         acc = 64'sd1686629713 + (acc * t2) / ONE_Q30;
         r   = (acc * t) / ONE_Q30;
         if (r < 0) r = 0;
         r = (r + 64'sd16384) / 64'sd32768;
         if (r > 64'sd32768) r = 64'sd32768;
         sine_quarter[i] = int'(r);
      end
   endfunction

   // one multiplexer read: updates pot state on an x read, returns the reading
   function automatic qpse_pkg::rsp_payload_type emulate_channel_read(input logic [7:0] ch,
                                                                     input logic [15:0] sl);
      qpse_pkg::rsp_payload_type res;
      int              k;
      int              ds;
      logic [11:0]     idx;
      int              v;
      longint          prod;
      logic [11:0]     rd;
      rd = qpse_pkg::MIDSCALE;
      if (ch == CH_BATT) begin
         rd = batt_reg;
      end else if (ch >= CH_POT_FIRST && ch <= CH_POT_LAST) begin
         k = (int'(ch) - 2) >> 1;
         // even channel is the x output
         if (!ch[0]) begin
            ds = int'(sl) - int'(pot_slider[k]);
            if (k == 0) ds = ds * 2;
            else if (k != 1) ds = -ds;
            pot_angle[k]  = pot_angle[k] + 16'(ds);
            pot_slider[k] = sl;
         end
         idx = pot_angle[k][15:4];
         if (!ch[0]) idx = idx + 12'(QUARTER_STEPS);
         v = idx[10] ? sine_quarter[QUARTER_STEPS - int'(idx[9:0])] : sine_quarter[idx[9:0]];
         if (idx[11]) v = -v;
         prod = longint'(v) * longint'(amp_reg) + MID_Q15;
         if (prod < 0) prod = 0;
         prod = prod / 64'sd32768;
         if (prod > 64'sd4095) prod = 64'sd4095;
         rd = 12'(prod);
      end
      res.reading   = rd;
      res.above_mid = (rd > qpse_pkg::MIDSCALE);
      return res;
   endfunction

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic send_word(input logic [7:0] ch, input logic [15:0] sl, input bit known,
                            input qpse_pkg::rsp_payload_type given);
      int                        gap;
      bit                        taken;
      qpse_pkg::rsp_payload_type calc;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {ch, sl};
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
      end
      calc = emulate_channel_read(ch, sl);
      predicted_readings.push_back(known ? given : calc);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (predicted_readings.size() != 0);
   endtask

   task automatic write_csr(input qpse_pkg::csr_index_type idx, input logic [11:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == qpse_pkg::CSR_AMPLITUDE) amp_reg = val[10:0];
      else batt_reg = val;
      @(negedge clock);
   endtask

   task automatic send_random_items(input int count, input bit hold_midway);
      int                        sent;
      int                        pick;
      int                        k;
      bit                        held;
      logic [7:0]                ch;
      logic [15:0]               sl;
      qpse_pkg::rsp_payload_type none;
      none = '0;
      sent = 0;
      held = 1'b0;
      while (sent < count) begin
         if (hold_midway && !held && sent >= count / 2) begin
            drain_results();
            held = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            k  = $urandom_range(0, POTS - 1);
            ch = 8'(int'(CH_POT_FIRST) + 2 * k);
            case ($urandom_range(0, 3))
               0: sl = 16'($urandom);
               1: sl = pot_slider[k] + 16'($urandom_range(0, 4094)) - 16'd2047;
               2: sl = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
               default: sl = pot_slider[k] + 16'($urandom_range(0, 32767)) - 16'd16384;
            endcase
            send_word(ch, sl, 1'b0, none);
            sent++;
            // a scan normally reads the matching y right after the x
            if ($urandom_range(0, 3) != 0) begin
               send_word(ch + 8'd1, 16'($urandom), 1'b0, none);
               sent++;
            end
         end else if (pick < 80) begin
            send_word(8'($urandom_range(0, 1)), 16'($urandom), 1'b0, none);
            sent++;
         end else if (pick < 88) begin
            ch = 8'(int'(CH_POT_FIRST) + 1 + 2 * $urandom_range(0, POTS - 1));
            send_word(ch, 16'($urandom), 1'b0, none);
            sent++;
         end else begin
            send_word(8'($urandom_range(16, 255)), 16'($urandom), 1'b0, none);
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic [11:0] amp_val, input logic [11:0] batt_val,
                            input bit no_idle, input bit hold_midway);
      drain_results();
      write_csr(qpse_pkg::CSR_AMPLITUDE, amp_val);
      write_csr(qpse_pkg::CSR_BATTERY, batt_val);
      quiet = no_idle;
      send_random_items(ITEMS_PER_PHASE, hold_midway);
   endtask

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      qpse_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_readings.size() == 0) begin
            flag_error($sformatf("unexpected word: reading %0d above_mid %0d",
                                 rsp_data.reading, rsp_data.above_mid));
         end else begin
            want = predicted_readings.pop_front();
            if (rsp_data.reading !== want.reading || rsp_data.above_mid !== want.above_mid)
               flag_error($sformatf("mismatch: expected reading %0d above_mid %0d, got %0d %0d",
                                    want.reading, want.above_mid,
                                    rsp_data.reading, rsp_data.above_mid));
         end
         rsp_stall = idle_draw();
      end
   end

   initial begin : stimulus
      qpse_pkg::rsp_payload_type given;
      fill_sine_quarter();
      amp_reg  = qpse_pkg::AMP_RESET;
      batt_reg = qpse_pkg::BATT_RESET;
      for (int k = 0; k < POTS; k++) begin
         pot_slider[k] = 16'd0;
         pot_angle[k]  = 16'd0;
      end
      pot_slider[0] = qpse_pkg::SLIDER0_RESET;
      pot_slider[1] = qpse_pkg::SLIDER1_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows run on the reset register values
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         given.reading   = stim_table[n].reading;
         given.above_mid = stim_table[n].above_mid;
         send_word(stim_table[n].channel, stim_table[n].slider, stim_table[n].known, given);
      end

      // amplitude write with bit 11 set checks the register mask
      run_phase(12'hFFF, 12'hFFF, 1'b0, 1'b0);
      run_phase(12'h000, 12'h000, 1'b1, 1'b0);
      run_phase(12'($urandom), 12'($urandom), 1'b0, 1'b1);
      run_phase(12'h001, 12'd2048, 1'b0, 1'b0);
      run_phase(12'hC00, 12'd2049, 1'b1, 1'b0);
      run_phase(12'($urandom), 12'($urandom), 1'b0, 1'b0);

      drain_results();
      repeat (8) @(negedge clock);
      if (predicted_readings.size() != 0)
         flag_error($sformatf("%0d expected words never arrived", predicted_readings.size()));
      if (fail_count == 0) begin
         $display("quadrature_pot_sensor_emulator_core regression: pass");
      end else begin
         $display("quadrature_pot_sensor_emulator_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("quadrature_pot_sensor_emulator_core regression: fail");
      $finish;
   end

endmodule
